FILE: rtl/core/kfr_pkg.sv
`default_nettype none

package kfr_pkg;

    // Queue geometry and field widths.
    localparam int DEPTH       = 16;
    localparam int KEY_BITS    = 16;
    localparam int HANDLE_BITS = 32;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    // Command codes carried by an input beat.
    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_FIND    = 2'd2,
        CMD_REMOVE  = 2'd3
    } t_cmd;

    // Status codes carried by a result beat.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    // Input beat.
    typedef struct packed {
        t_cmd                   command;
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] handle;
    } t_cmd_beat;

    // Result beat.
    typedef struct packed {
        t_status                status;
        logic [HANDLE_BITS-1:0] handle_out;
        logic                   head_valid;
        logic [KEY_BITS-1:0]    head_key;
        logic [HANDLE_BITS-1:0] head_handle;
        logic [CNT_W-1:0]       entry_count;
    } t_res_beat;

    // One slot of the entry memory.
    typedef struct packed {
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] handle;
    } t_entry;

endpackage

`default_nettype wire

FILE: rtl/core/keyed_fifo_with_remove_unit.sv
`default_nettype none

// Channel   Direction  Handshake                    Beat
// command   in         i_in_valid / o_in_stall      i_in_data  (t_cmd_beat)
// result    out        o_out_valid / i_out_stall    o_out_data (t_res_beat)
//
// Entries live in a circular buffer memory (one write port, one registered read port).
// Enqueue passes through S_HEAD and S_OUT, dequeue through S_POP, S_HEAD and S_OUT. Find scans
// the entries from the oldest at one read a cycle. A remove then moves every younger entry
// one slot toward the head, one slot a cycle, before it too passes through S_HEAD and S_OUT.
// One command is worked on at a time; the next is accepted once the result is registered,
// and a waiting result that is stalled holds the command in S_OUT.
// Reset clears the counters and the result valid; memory contents are left as they are.
module keyed_fifo_with_remove_unit
    import kfr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_cmd_beat i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_res_beat      o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_SHIFT,
        S_HEAD,
        S_OUT
    } t_state;

    // Position in arrival order to memory address, wrapping at DEPTH.
    function automatic logic [PTR_W-1:0] f_addr(input logic [PTR_W-1:0] base,
                                                input logic [PTR_W-1:0] pos);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, pos};
        if (sum >= (PTR_W+1)'(DEPTH)) begin
            sum = sum - (PTR_W+1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    t_state                 r_state,  n_state;
    t_cmd                   r_cmd,    n_cmd;
    logic [KEY_BITS-1:0]    r_key,    n_key;
    t_status                r_status, n_status;
    logic [HANDLE_BITS-1:0] r_hout,   n_hout;
    logic [PTR_W-1:0]       r_head,   n_head;
    logic [CNT_W-1:0]       r_count,  n_count;
    logic [CNT_W-1:0]       r_idx,    n_idx;
    logic [CNT_W-1:0]       r_pidx,   n_pidx;
    logic                   r_pend,   n_pend;
    logic                   r_out_valid, n_out_valid;
    t_res_beat              r_out,    n_out;

    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    t_entry           mem_wdata;
    logic             mem_re;
    logic [PTR_W-1:0] mem_raddr;

    logic [CNT_W:0] w_idx1;
    logic [CNT_W:0] w_idx2;
    logic [CNT_W:0] w_cnt;
    logic           w_accept;

    assign w_idx1   = {1'b0, r_idx} + (CNT_W+1)'(1);
    assign w_idx2   = {1'b0, r_idx} + (CNT_W+1)'(2);
    assign w_cnt    = {1'b0, r_count};
    assign w_accept = i_in_valid && (r_state == S_IDLE);

    // Sequencer: next state, counters and memory port controls.
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_status    = r_status;
        n_hout      = r_hout;
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pidx      = r_pidx;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_waddr   = r_head;
        mem_wdata   = r_rd_data;
        mem_re      = 1'b0;
        mem_raddr   = r_head;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd    = i_in_data.command;
                    n_key    = i_in_data.key;
                    n_status = ST_OK;
                    n_hout   = '0;
                    n_idx    = '0;
                    n_pend   = 1'b0;
                    case (i_in_data.command)
                        CMD_ENQUEUE: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we           = 1'b1;
                                mem_waddr        = f_addr(r_head, r_count[PTR_W-1:0]);
                                mem_wdata.key    = i_in_data.key;
                                mem_wdata.handle = i_in_data.handle;
                                n_count          = r_count + CNT_W'(1);
                            end
                            n_state = S_HEAD;
                        end
                        CMD_DEQUEUE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_HEAD;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = S_POP;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_status = ST_MISSING;
                                n_state  = S_HEAD;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                    endcase
                end
            end

            // The oldest entry is on the read port; drop it.
            S_POP: begin
                n_hout  = r_rd_data.handle;
                n_head  = f_addr(r_head, PTR_W'(1));
                n_count = r_count - CNT_W'(1);
                n_state = S_HEAD;
            end

            // One read issued per cycle; the previous read is compared.
            S_SCAN: begin
                if (r_pend && (r_rd_data.key == r_key)) begin
                    n_pend = 1'b0;
                    if (r_cmd == CMD_FIND) begin
                        n_hout  = r_rd_data.handle;
                        n_state = S_HEAD;
                    end else begin
                        n_idx   = r_pidx;
                        n_state = S_SHIFT;
                    end
                end else if (r_idx < r_count) begin
                    mem_re    = 1'b1;
                    mem_raddr = f_addr(r_head, r_idx[PTR_W-1:0]);
                    n_pidx    = r_idx;
                    n_pend    = 1'b1;
                    n_idx     = w_idx1[CNT_W-1:0];
                end else begin
                    n_status = ST_MISSING;
                    n_pend   = 1'b0;
                    n_state  = S_HEAD;
                end
            end

            // Close the gap: the entry read last cycle moves one slot toward the head.
            S_SHIFT: begin
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = f_addr(r_head, r_idx[PTR_W-1:0]);
                    mem_wdata = r_rd_data;
                    n_idx     = w_idx1[CNT_W-1:0];
                    if (w_idx2 < w_cnt) begin
                        mem_re    = 1'b1;
                        mem_raddr = f_addr(r_head, w_idx2[PTR_W-1:0]);
                        n_pend    = 1'b1;
                    end else begin
                        n_pend = 1'b0;
                    end
                end else if (w_idx1 < w_cnt) begin
                    mem_re    = 1'b1;
                    mem_raddr = f_addr(r_head, w_idx1[PTR_W-1:0]);
                    n_pend    = 1'b1;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_HEAD;
                end
            end

            // Fetch the head entry for the result.
            S_HEAD: begin
                mem_re  = 1'b1;
                n_state = S_OUT;
            end

            // Load the result register once it is free.
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.status      = r_status;
                    n_out.handle_out  = r_hout;
                    n_out.entry_count = r_count;
                    if (r_count != '0) begin
                        n_out.head_valid  = 1'b1;
                        n_out.head_key    = r_rd_data.key;
                        n_out.head_handle = r_rd_data.handle;
                    end else begin
                        n_out.head_valid  = 1'b0;
                        n_out.head_key    = '0;
                        n_out.head_handle = '0;
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Entry memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    // State, counters and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_status <= n_status;
        r_hout   <= n_hout;
        r_idx    <= n_idx;
        r_pidx   <= n_pidx;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
